/* rtl/core/dete_pkg.sv */
package dete_pkg;

    // Operation codes
    localparam logic [1:0] FUNC_ADD    = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_TEST   = 2'd2;
    localparam logic [1:0] FUNC_DEGREE = 2'd3;

    // Result status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_DUP     = 3'd1;
    localparam logic [2:0] ST_MISSING = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_BADV    = 3'd4;

    // Vertex count register
    localparam int          VTOTAL_W     = 9;
    localparam logic [8:0]  VTOTAL_RESET = 9'd256;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CMP   = 4'b0010,
        S_APPLY = 4'b0100,
        S_FIN   = 4'b1000
    } seq_state_t;

    // Broadcast control from sequencer to every cell
    typedef struct packed {
        logic capture;   // register hit and degree bits
        logic load_new;  // append key at the cell whose index equals the count
        logic shift;     // cells at or above the hit take their upper neighbor
    } cell_ctrl_t;

endpackage

/* rtl/core/directed_edge_table_core.sv */
// Directed edge table: ordered list of up to MAX_EDGES directed edges.
// Input channel (in_valid/in_stall) carries one operation per beat:
// func selects add, remove, test or out-degree on source_vertex and
// sink_vertex. Output channel (out_valid/out_stall) returns one beat per
// operation with status, found, degree and the edge count afterwards.
// Each list entry lives in its own cell; all cells compare the key in
// parallel, and on remove every cell at or above the hit takes its upper neighbor's
// entry in the same cycle.
// Add, remove and test pass through the compare, apply and finish states
// before out_valid rises; out-degree also waits for its registered adder
// tree, which sums the cell match bits. A new operation is accepted only
// once the sequencer is back in idle. A finished result waits in the output
// register while the block takes the next operation; if the receiver still
// stalls when the next result is ready, the sequencer holds until the output
// register frees up. Reset empties the list and sets vertex_total to 256;
// the entries themselves are not cleared. cfg_wr_en writes vertex_total; it
// is to be written only while idle, which the block itself does not enforce.
module directed_edge_table_core #(
    parameter int MAX_EDGES   = 256,
    parameter int VERTEX_BITS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [dete_pkg::VTOTAL_W-1:0] cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    func,
    input  logic [VERTEX_BITS-1:0]        source_vertex,
    input  logic [VERTEX_BITS-1:0]        sink_vertex,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [2:0]                    status,
    output logic                          found,
    output logic [$clog2(MAX_EDGES+1)-1:0] degree,
    output logic [$clog2(MAX_EDGES+1)-1:0] edge_total
);

    localparam int CNT_W    = $clog2(MAX_EDGES + 1);
    localparam int IDX_W    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CMP_W    = (VERTEX_BITS > dete_pkg::VTOTAL_W) ?
                              VERTEX_BITS : dete_pkg::VTOTAL_W;
    localparam int TREE_LAT = $clog2(MAX_EDGES) + 1;
    localparam int TC_W     = $clog2(TREE_LAT + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_EDGES);

    // Configuration
    logic [dete_pkg::VTOTAL_W-1:0] vtotal_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vtotal_reg <= dete_pkg::VTOTAL_RESET;
        else if (cfg_wr_en)
            vtotal_reg <= cfg_wr_data;
    end

    // Sequencer and operation registers
    dete_pkg::seq_state_t state_reg, state_next;
    logic [1:0]             op_func_reg;
    logic [VERTEX_BITS-1:0] op_src_reg;
    logic [VERTEX_BITS-1:0] op_snk_reg;
    logic                   op_bad_reg;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [2:0]             pend_status_reg, pend_status_next;
    logic                   pend_found_reg, pend_found_next;
    logic [TC_W-1:0]        tree_cnt_reg;

    logic accept;
    logic src_ok, snk_ok, in_bad;
    logic out_load;
    logic is_degree, tree_ready;

    assign in_stall = (state_reg != dete_pkg::S_IDLE);
    assign accept   = in_valid && !in_stall;

    // Vertex range check at accept
    assign src_ok = (CMP_W'(source_vertex) < CMP_W'(vtotal_reg));
    assign snk_ok = (CMP_W'(sink_vertex) < CMP_W'(vtotal_reg));
    assign in_bad = (func == dete_pkg::FUNC_DEGREE) ? !src_ok :
                    (!src_ok || !snk_ok || (source_vertex == sink_vertex));

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_func_reg <= func;
            op_src_reg  <= source_vertex;
            op_snk_reg  <= sink_vertex;
            op_bad_reg  <= in_bad;
        end
    end

    // Cell row
    logic [VERTEX_BITS-1:0] ent_src [0:MAX_EDGES-1];
    logic [VERTEX_BITS-1:0] ent_snk [0:MAX_EDGES-1];
    logic [MAX_EDGES-1:0]   hit_vec;
    logic [MAX_EDGES-1:0]   deg_vec;
    logic [IDX_W-1:0]       hit_pos;
    logic                   any_hit;
    dete_pkg::cell_ctrl_t   cell_ctrl;

    genvar i;
    generate
        for (i = 0; i < MAX_EDGES; i++)
        begin : g_cell
            logic [VERTEX_BITS-1:0] up_src;
            logic [VERTEX_BITS-1:0] up_snk;

            if (i + 1 < MAX_EDGES)
            begin : g_mid
                assign up_src = ent_src[i+1];
                assign up_snk = ent_snk[i+1];
            end
            else
            begin : g_top
                assign up_src = ent_src[i];
                assign up_snk = ent_snk[i];
            end

            dete_cell #(
                .VERTEX_BITS (VERTEX_BITS),
                .CNT_W       (CNT_W),
                .IDX_W       (IDX_W),
                .INDEX       (i)
            ) u_cell (
                .clk        (clk),
                .ctrl       (cell_ctrl),
                .held_count (count_reg),
                .hit_pos    (hit_pos),
                .key_src    (op_src_reg),
                .key_snk    (op_snk_reg),
                .upper_src  (up_src),
                .upper_snk  (up_snk),
                .src        (ent_src[i]),
                .snk        (ent_snk[i]),
                .hit        (hit_vec[i]),
                .deg_bit    (deg_vec[i])
            );
        end
    endgenerate

    // Hit position: the list holds no duplicates, so at most one bit is set
    always_comb
    begin
        hit_pos = '0;
        for (int n = 0; n < MAX_EDGES; n++)
        begin
            if (hit_vec[n])
                hit_pos = hit_pos | IDX_W'(n);
        end
    end

    assign any_hit = |hit_vec;

    // Out-degree adder tree
    logic [CNT_W-1:0] deg_total;

    dete_count_tree #(
        .LEAVES (MAX_EDGES),
        .CNT_W  (CNT_W)
    ) u_tree (
        .clk   (clk),
        .bits  (deg_vec),
        .total (deg_total)
    );

    // Tree latency counter, started when the match bits are captured
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tree_cnt_reg <= '0;
        else if (state_reg == dete_pkg::S_CMP)
            tree_cnt_reg <= TC_W'(TREE_LAT);
        else if (tree_cnt_reg != '0)
            tree_cnt_reg <= tree_cnt_reg - 1'b1;
    end

    assign is_degree  = (op_func_reg == dete_pkg::FUNC_DEGREE) && !op_bad_reg;
    assign tree_ready = !is_degree || (tree_cnt_reg == '0);
    assign out_load   = (state_reg == dete_pkg::S_FIN) && tree_ready &&
                        (!out_valid || !out_stall);

    // Operation decode in the apply cycle
    always_comb
    begin
        cell_ctrl         = '0;
        cell_ctrl.capture = (state_reg == dete_pkg::S_CMP);
        count_next        = count_reg;
        pend_status_next  = pend_status_reg;
        pend_found_next   = pend_found_reg;

        if (state_reg == dete_pkg::S_APPLY)
        begin
            pend_status_next = dete_pkg::ST_OK;
            pend_found_next  = 1'b0;
            if (op_bad_reg)
                pend_status_next = dete_pkg::ST_BADV;
            else
            begin
                case (op_func_reg)
                    dete_pkg::FUNC_ADD:
                    begin
                        if (any_hit)
                            pend_status_next = dete_pkg::ST_DUP;
                        else if (count_reg >= FULL_CNT)
                            pend_status_next = dete_pkg::ST_FULL;
                        else
                        begin
                            cell_ctrl.load_new = 1'b1;
                            count_next         = count_reg + 1'b1;
                        end
                    end
                    dete_pkg::FUNC_REMOVE:
                    begin
                        if (!any_hit)
                            pend_status_next = dete_pkg::ST_MISSING;
                        else
                        begin
                            cell_ctrl.shift = 1'b1;
                            count_next      = count_reg - 1'b1;
                        end
                    end
                    dete_pkg::FUNC_TEST:
                    begin
                        pend_found_next = any_hit;
                    end
                    default:
                    begin
                        pend_status_next = dete_pkg::ST_OK;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        pend_status_reg <= pend_status_next;
        pend_found_reg  <= pend_found_next;
    end

    // State transitions
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dete_pkg::S_IDLE:
            begin
                if (accept)
                    state_next = dete_pkg::S_CMP;
            end
            dete_pkg::S_CMP:   state_next = dete_pkg::S_APPLY;
            dete_pkg::S_APPLY: state_next = dete_pkg::S_FIN;
            dete_pkg::S_FIN:
            begin
                if (out_load)
                    state_next = dete_pkg::S_IDLE;
            end
            default:           state_next = dete_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= dete_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // Output register
    logic                   out_valid_reg, out_valid_next;
    logic [2:0]             out_status_reg;
    logic                   out_found_reg;
    logic [CNT_W-1:0]       out_degree_reg;
    logic [CNT_W-1:0]       out_total_reg;

    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else
            out_valid_next = out_valid_reg && out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg <= pend_status_reg;
            out_found_reg  <= pend_found_reg;
            out_degree_reg <= is_degree ? deg_total : '0;
            out_total_reg  <= count_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign found      = out_found_reg;
    assign degree     = out_degree_reg;
    assign edge_total = out_total_reg;

endmodule

/* rtl/core/dete_cell.sv */
module dete_cell #(
    parameter int VERTEX_BITS = 8,
    parameter int CNT_W       = 9,
    parameter int IDX_W       = 8,
    parameter int INDEX       = 0
) (
    input  logic                   clk,
    input  dete_pkg::cell_ctrl_t   ctrl,
    input  logic [CNT_W-1:0]       held_count,
    input  logic [IDX_W-1:0]       hit_pos,
    input  logic [VERTEX_BITS-1:0] key_src,
    input  logic [VERTEX_BITS-1:0] key_snk,
    input  logic [VERTEX_BITS-1:0] upper_src,
    input  logic [VERTEX_BITS-1:0] upper_snk,
    output logic [VERTEX_BITS-1:0] src,
    output logic [VERTEX_BITS-1:0] snk,
    output logic                   hit,
    output logic                   deg_bit
);

    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(INDEX);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [VERTEX_BITS-1:0] src_reg;
    logic [VERTEX_BITS-1:0] snk_reg;
    logic                   hit_reg;
    logic                   deg_reg;
    logic                   occupied;

    assign occupied = (MY_CNT < held_count);

    // Compare against the broadcast key
    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            hit_reg <= occupied && (src_reg == key_src) && (snk_reg == key_snk);
            deg_reg <= occupied && (src_reg == key_src);
        end
    end

    // Entry update: append or shift down from the neighbor
    always_ff @(posedge clk)
    begin
        if (ctrl.load_new && (held_count == MY_CNT))
        begin
            src_reg <= key_src;
            snk_reg <= key_snk;
        end
        else if (ctrl.shift && (MY_IDX >= hit_pos))
        begin
            src_reg <= upper_src;
            snk_reg <= upper_snk;
        end
    end

    assign src     = src_reg;
    assign snk     = snk_reg;
    assign hit     = hit_reg;
    assign deg_bit = deg_reg;

endmodule

/* rtl/core/dete_count_tree.sv */
module dete_count_tree #(
    parameter int LEAVES = 256,
    parameter int CNT_W  = 9
) (
    input  logic              clk,
    input  logic [LEAVES-1:0] bits,
    output logic [CNT_W-1:0]  total
);

    localparam int LEVELS = $clog2(LEAVES);
    localparam int PAD    = 1 << LEVELS;

    logic [CNT_W-1:0] node_reg [0:LEVELS][0:PAD-1];

    genvar k, j;
    generate
        // Leaf level: register each bit, padding with zero
        for (j = 0; j < PAD; j++)
        begin : g_leaf
            if (j < LEAVES)
            begin : g_used
                always_ff @(posedge clk)
                begin
                    node_reg[0][j] <= CNT_W'(bits[j]);
                end
            end
            else
            begin : g_pad
                always_ff @(posedge clk)
                begin
                    node_reg[0][j] <= '0;
                end
            end
        end

        // Pairwise adder levels, one register stage each
        for (k = 1; k <= LEVELS; k++)
        begin : g_lvl
            for (j = 0; j < PAD; j++)
            begin : g_node
                if (j < (PAD >> k))
                begin : g_sum
                    always_ff @(posedge clk)
                    begin
                        node_reg[k][j] <= node_reg[k-1][2*j] + node_reg[k-1][2*j+1];
                    end
                end
                else
                begin : g_zero
                    always_ff @(posedge clk)
                    begin
                        node_reg[k][j] <= '0;
                    end
                end
            end
        end
    endgenerate

    assign total = node_reg[LEVELS][0];

endmodule

/* dv/edge_table_sb_pkg.sv */
package edge_table_sb_pkg;

    localparam int EDGE_CAPACITY = 256;

    typedef struct packed {
        logic [7:0] src;
        logic [7:0] snk;
    } dir_edge_t;

    typedef struct packed {
        logic [2:0] status;
        logic       found;
        logic [8:0] degree;
        logic [8:0] edge_total;
    } edge_result_t;

    class edge_table_scoreboard;

        // Shadow copy of the block's state
        logic [8:0]   vtotal_shadow;
        dir_edge_t    edge_list[$];
        edge_result_t op_results[$];

        int unsigned mismatches;
        int unsigned ops_noted;
        int unsigned beats_checked;
        int unsigned peak_edges;

        function new();
            vtotal_shadow = dete_pkg::VTOTAL_RESET;
            mismatches    = 0;
            ops_noted     = 0;
            beats_checked = 0;
            peak_edges    = 0;
        endfunction

        function bit vertex_ok(logic [7:0] v);
            return {1'b0, v} < vtotal_shadow;
        endfunction

        function int unsigned pending();
            return op_results.size();
        endfunction

        // Apply one accepted operation to the shadow list, queue its result
        function void apply_edge_op(logic [1:0] op, logic [7:0] s, logic [7:0] t);
            edge_result_t r;
            int           pos;
            r   = '0;
            pos = -1;
            if (op == dete_pkg::FUNC_DEGREE)
            begin
                if (!vertex_ok(s))
                    r.status = dete_pkg::ST_BADV;
                else
                    foreach (edge_list[i])
                        if (edge_list[i].src == s)
                            r.degree = r.degree + 9'd1;
            end
            else if (!vertex_ok(s) || !vertex_ok(t) || s == t)
            begin
                r.status = dete_pkg::ST_BADV;
            end
            else
            begin
                foreach (edge_list[i])
                    if (pos < 0 && edge_list[i].src == s && edge_list[i].snk == t)
                        pos = i;
                case (op)
                    dete_pkg::FUNC_ADD:
                    begin
                        // duplicate check wins over full
                        if (pos >= 0)
                            r.status = dete_pkg::ST_DUP;
                        else if (edge_list.size() >= EDGE_CAPACITY)
                            r.status = dete_pkg::ST_FULL;
                        else
                            edge_list.push_back('{src: s, snk: t});
                    end
                    dete_pkg::FUNC_REMOVE:
                    begin
                        if (pos < 0)
                            r.status = dete_pkg::ST_MISSING;
                        else
                            edge_list.delete(pos);
                    end
                    default:
                        r.found = (pos >= 0);
                endcase
            end
            r.edge_total = 9'(edge_list.size());
            if (edge_list.size() > peak_edges)
                peak_edges = edge_list.size();
            op_results.push_back(r);
            ops_noted++;
        endfunction

        // Compare one result beat against the oldest outstanding result
        function void check_result(logic [2:0] st, logic fd, logic [8:0] dg,
                                   logic [8:0] tot);
            edge_result_t want;
            beats_checked++;
            if (op_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result beat %0d with no operation outstanding",
                             beats_checked);
                return;
            end
            want = op_results.pop_front();
            if (want.status !== st || want.found !== fd || want.degree !== dg ||
                want.edge_total !== tot)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"ERROR: beat %0d exp status=%0d found=%0d degree=%0d ",
                              "total=%0d, got status=%0d found=%0d degree=%0d total=%0d"},
                             beats_checked, want.status, want.found, want.degree,
                             want.edge_total, st, fd, dg, tot);
            end
        endfunction

    endclass

endpackage

/* dv/tb_directed_edge_table_core.sv */
module tb_directed_edge_table_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES = 80;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [8:0] cfg_wr_data;
    logic       in_valid;
    logic       in_stall;
    logic [1:0] func;
    logic [7:0] source_vertex;
    logic [7:0] sink_vertex;
    logic       out_valid;
    logic       out_stall;
    logic [2:0] status;
    logic       found;
    logic [8:0] degree;
    logic [8:0] edge_total;

    // idle rates in percent, and a request for a long receiver hold-off
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    bit          hold_req = 1'b0;

    edge_table_sb_pkg::edge_table_scoreboard sb = new();

    directed_edge_table_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .source_vertex (source_vertex),
        .sink_vertex   (sink_vertex),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .found         (found),
        .degree        (degree),
        .edge_total    (edge_total)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: random stalls, or one long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // Result beats
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(status, found, degree, edge_total);
    end

    // Offer one operation beat, note it when accepted
    task automatic send_op(input logic [1:0] op, input logic [7:0] s,
                           input logic [7:0] t);
        @(negedge clk);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        func          <= op;
        source_vertex <= s;
        sink_vertex   <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.apply_edge_op(op, s, t);
    endtask

    task automatic wait_results_done();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic set_vertex_total(input logic [8:0] v);
        wait_results_done();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        sb.vtotal_shadow = v;
    endtask

    // Mostly in-range vertices (one past the top included), some fully random
    function automatic logic [7:0] pick_vertex();
        int lim;
        lim = (sb.vtotal_shadow > 9'd255) ? 255 : int'(sb.vtotal_shadow);
        if ($urandom_range(99) < 15)
            return 8'($urandom);
        return 8'($urandom_range(lim));
    endfunction

    // Random operations; half of remove/test/add hit an edge already held
    task automatic run_mixed(input int count);
        logic [1:0] op;
        logic [7:0] s;
        logic [7:0] t;
        edge_table_sb_pkg::dir_edge_t e;
        for (int n = 0; n < count; n++)
        begin
            op = 2'($urandom_range(3));
            s  = pick_vertex();
            t  = pick_vertex();
            if (op != dete_pkg::FUNC_DEGREE && sb.edge_list.size() != 0 &&
                $urandom_range(1))
            begin
                e = sb.edge_list[$urandom_range(sb.edge_list.size() - 1)];
                s = e.src;
                t = e.snk;
            end
            send_op(op, s, t);
        end
    endtask

    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        int        guard;
        int        r;
        logic [7:0] s;
        logic [7:0] t;
        edge_table_sb_pkg::dir_edge_t e;

        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        in_valid      = 1'b0;
        func          = dete_pkg::FUNC_ADD;
        source_vertex = '0;
        sink_vertex   = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // sender light idling, receiver heavy stalls
        send_idle_pct  = 21;
        recv_stall_pct = 82;

        // directed: empty list, duplicates, self-loop, middle removal
        send_op(dete_pkg::FUNC_REMOVE, 8'd3, 8'd7);
        send_op(dete_pkg::FUNC_TEST, 8'd3, 8'd7);
        send_op(dete_pkg::FUNC_DEGREE, 8'd0, 8'd0);
        send_op(dete_pkg::FUNC_ADD, 8'd0, 8'd255);
        send_op(dete_pkg::FUNC_ADD, 8'd255, 8'd0);
        send_op(dete_pkg::FUNC_ADD, 8'd0, 8'd255);
        send_op(dete_pkg::FUNC_ADD, 8'd9, 8'd9);
        send_op(dete_pkg::FUNC_TEST, 8'd0, 8'd255);
        send_op(dete_pkg::FUNC_DEGREE, 8'd255, 8'd17);
        send_op(dete_pkg::FUNC_ADD, 8'd0, 8'd1);
        send_op(dete_pkg::FUNC_ADD, 8'd0, 8'd2);
        send_op(dete_pkg::FUNC_DEGREE, 8'd0, 8'd255);
        send_op(dete_pkg::FUNC_REMOVE, 8'd0, 8'd1);
        send_op(dete_pkg::FUNC_TEST, 8'd0, 8'd2);
        send_op(dete_pkg::FUNC_TEST, 8'd0, 8'd1);
        send_op(dete_pkg::FUNC_REMOVE, 8'd0, 8'd1);
        send_op(dete_pkg::FUNC_DEGREE, 8'hAA, 8'h55);

        // small vertex range: held edges beyond it become bad vertices
        set_vertex_total(9'd4);
        send_op(dete_pkg::FUNC_ADD, 8'd4, 8'd1);
        send_op(dete_pkg::FUNC_ADD, 8'd1, 8'd4);
        send_op(dete_pkg::FUNC_DEGREE, 8'd4, 8'd0);
        send_op(dete_pkg::FUNC_DEGREE, 8'd3, 8'd0);
        send_op(dete_pkg::FUNC_TEST, 8'd255, 8'd0);
        send_op(dete_pkg::FUNC_REMOVE, 8'd0, 8'd2);
        send_op(dete_pkg::FUNC_ADD, 8'd3, 8'd0);
        send_op(dete_pkg::FUNC_DEGREE, 8'd0, 8'd3);

        // dense random traffic over few vertices
        set_vertex_total(9'd8);
        run_mixed(200);

        // heavy sender idling, light receiver stalls; fill the list
        send_idle_pct  = 82;
        recv_stall_pct = 21;
        set_vertex_total(9'd511);
        guard = 0;
        while (sb.edge_list.size() < edge_table_sb_pkg::EDGE_CAPACITY && guard < 600)
        begin
            s = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom);
            t = 8'($urandom);
            send_op(dete_pkg::FUNC_ADD, s, t);
            guard++;
        end

        // full list: new adds refused, duplicates still reported
        for (int n = 0; n < 40; n++)
        begin
            r = $urandom_range(99);
            e = sb.edge_list[$urandom_range(sb.edge_list.size() - 1)];
            if (r < 30)
                send_op(dete_pkg::FUNC_ADD, 8'($urandom), 8'($urandom));
            else if (r < 60)
                send_op(dete_pkg::FUNC_ADD, e.src, e.snk);
            else if (r < 80)
                send_op(dete_pkg::FUNC_TEST, e.src,
                        ($urandom_range(1) ? e.snk : 8'($urandom)));
            else
                send_op(dete_pkg::FUNC_DEGREE, ($urandom_range(1) ? 8'd0 : e.src),
                        8'($urandom));
        end

        // no idling; long receiver hold-off while draining the list
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b1;
        guard          = 0;
        while (sb.edge_list.size() != 0 && guard < 500)
        begin
            r = $urandom_range(99);
            e = sb.edge_list[$urandom_range(sb.edge_list.size() - 1)];
            if (r < 75)
                send_op(dete_pkg::FUNC_REMOVE, e.src, e.snk);
            else if (r < 85)
                send_op(dete_pkg::FUNC_TEST, e.src, e.snk);
            else if (r < 92)
                send_op(dete_pkg::FUNC_DEGREE, e.src, 8'($urandom));
            else
                send_op(dete_pkg::FUNC_REMOVE, 8'($urandom), 8'($urandom));
            guard++;
        end
        send_op(dete_pkg::FUNC_REMOVE, 8'd1, 8'd2);

        // tiny and degenerate vertex counts
        set_vertex_total(9'd2);
        run_mixed(40);
        set_vertex_total(9'd1);
        run_mixed(25);
        set_vertex_total(9'd0);
        run_mixed(15);

        // full range again, with a pause until every result is back
        set_vertex_total(9'd256);
        run_mixed(50);
        wait_results_done();
        run_mixed(50);

        wait_results_done();
        repeat (20) @(posedge clk);
        $display("Covered %0d operations (%0d result beats), vertex counts 0 to 511,",
                 sb.ops_noted, sb.beats_checked);
        $display("list grown to %0d edges, %0d mismatches.", sb.peak_edges,
                 sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
